// ===== sv/tsq_pkg.sv =====
package tsq_pkg;

    // Default build values for the queue
    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned TAG_BITS_DEF    = 16;

    // Fixed field widths
    localparam int unsigned TIME_W = 64;
    localparam int unsigned OTAG_W = 16;
    localparam int unsigned IVL_W  = 32;

    // Opcodes of an input request
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // One result request
    typedef struct packed {
        logic              fired;
        logic [OTAG_W-1:0] tag;
        logic              reprogram;
        logic              enable;
        logic [IVL_W-1:0]  interval;
        logic              rejected;
        logic              last;
    } t_res;

endpackage

// ===== sv/tsq_ram.sv =====
module tsq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/tsq_out.sv =====
module tsq_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsq_pkg::t_res i_res,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output tsq_pkg::t_res o_res
);
    import tsq_pkg::*;

    logic r_valid;
    t_res r_res;

    // Slot is free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/tsq_ctrl.sv =====
module tsq_ctrl #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TAG_BITS    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input request
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_opcode,
    input  logic [tsq_pkg::TIME_W-1:0]           i_now,
    input  logic [tsq_pkg::TIME_W-1:0]           i_delay,
    input  logic [tsq_pkg::OTAG_W-1:0]           i_tag,
    // result request
    output logic                                 o_push,
    input  logic                                 i_free,
    output tsq_pkg::t_res                        o_res,
    // entry memory
    output logic                                 o_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       o_waddr,
    output logic [tsq_pkg::TIME_W+TAG_BITS-1:0]  o_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]       o_raddr,
    input  logic [tsq_pkg::TIME_W+TAG_BITS-1:0]  i_rdata
);
    import tsq_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam int unsigned EW = TIME_W + TAG_BITS;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_ADD_START = 6'b000010,
        S_ADD_WALK  = 6'b000100,
        S_ADD_HEAD  = 6'b001000,
        S_ADD_FIN   = 6'b010000,
        S_CHK       = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [PW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [TIME_W-1:0]   r_dl, n_dl;
    logic [IVL_W-1:0]    r_ivl, n_ivl;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_pos0, n_pos0;
    logic                r_rej, n_rej;

    logic [TIME_W-1:0]   q_dl;
    logic [TAG_BITS-1:0] q_tag;
    logic [63:0]         q_tag64;
    logic [63:0]         in_tag64;
    logic [EW-1:0]       new_word;
    logic                shift;

    // Logical queue slot to memory address, ring of QUEUE_DEPTH entries
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign q_dl     = i_rdata[EW-1:TAG_BITS];
    assign q_tag    = i_rdata[TAG_BITS-1:0];
    assign q_tag64  = 64'(q_tag);
    assign in_tag64 = 64'(i_tag);
    assign new_word = {r_dl, r_tag};
    assign o_ready  = (r_state == S_IDLE);

    // Sequencer: insert walks back from the tail, check pops from the head
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_idx   = r_idx;
        n_now   = r_now;
        n_dl    = r_dl;
        n_ivl   = r_ivl;
        n_tag   = r_tag;
        n_pos0  = r_pos0;
        n_rej   = r_rej;
        o_we    = 1'b0;
        o_waddr = r_head;
        o_wdata = new_word;
        o_raddr = r_head;
        o_push  = 1'b0;
        o_res   = '0;
        shift   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_now = i_now;
                    n_dl  = i_now + i_delay;
                    n_ivl = i_delay[IVL_W-1:0];
                    n_tag = in_tag64[TAG_BITS-1:0];
                    if (i_opcode == OP_CHECK) begin
                        n_state = S_CHK;
                    end else begin
                        n_state = S_ADD_START;
                    end
                end
            end
            S_ADD_START: begin
                n_rej  = 1'b0;
                n_pos0 = 1'b0;
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_rej   = 1'b1;
                    n_state = S_ADD_FIN;
                end else if (r_count == '0) begin
                    o_we    = 1'b1;
                    o_waddr = r_head;
                    n_count = r_count + CW'(1);
                    n_pos0  = 1'b1;
                    n_state = S_ADD_FIN;
                end else begin
                    o_raddr = phys(r_head, r_count - CW'(1));
                    n_idx   = r_count - CW'(1);
                    n_state = S_ADD_WALK;
                end
            end
            S_ADD_WALK: begin
                // next lower slot is read ahead while this one is decided
                o_raddr = phys(r_head, r_idx - CW'(1));
                if (r_idx != '0) begin
                    shift = (q_dl >= r_dl);
                end else begin
                    shift = (r_dl < q_dl);
                end
                o_we    = 1'b1;
                o_waddr = phys(r_head, r_idx + CW'(1));
                if (shift) begin
                    o_wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_ADD_HEAD;
                    end else begin
                        n_idx = r_idx - CW'(1);
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_ADD_FIN;
                end
            end
            S_ADD_HEAD: begin
                o_we    = 1'b1;
                o_waddr = r_head;
                n_count = r_count + CW'(1);
                n_pos0  = 1'b1;
                n_state = S_ADD_FIN;
            end
            S_ADD_FIN: begin
                o_push          = 1'b1;
                o_res.enable    = 1'b1;
                o_res.rejected  = r_rej;
                o_res.reprogram = r_pos0;
                o_res.interval  = r_pos0 ? r_ivl : '0;
                o_res.last      = 1'b1;
                if (i_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CHK: begin
                o_push = 1'b1;
                if (r_count == '0) begin
                    // queue drained: timer off
                    o_res.reprogram = 1'b1;
                    o_res.last      = 1'b1;
                    if (i_free) begin
                        n_state = S_IDLE;
                    end
                end else if (q_dl <= r_now) begin
                    o_res.fired = 1'b1;
                    o_res.tag   = q_tag64[OTAG_W-1:0];
                    if (i_free) begin
                        n_head  = phys(r_head, CW'(1));
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    o_res.reprogram = 1'b1;
                    o_res.enable    = 1'b1;
                    o_res.interval  = q_dl[IVL_W-1:0] - r_now[IVL_W-1:0];
                    o_res.last      = 1'b1;
                    if (i_free) begin
                        n_state = S_IDLE;
                    end
                end
                // read the head that stands after this cycle
                o_raddr = n_head;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_now  <= n_now;
        r_dl   <= n_dl;
        r_ivl  <= n_ivl;
        r_tag  <= n_tag;
        r_pos0 <= n_pos0;
        r_rej  <= n_rej;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < (PW+1)'(QUEUE_DEPTH))
        else $error("head pointer out of ring");

    a_walk_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WALK && r_idx != '0) |-> (o_waddr != o_raddr))
        else $error("insert walk reads the slot it writes");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_free && o_res.last) |=> (r_state == S_IDLE))
        else $error("final result did not end the request");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state != S_IDLE))
        else $error("accepted request left sequencer idle");

endmodule

// ===== sv/sorted_timer_event_queue_unit.sv =====
// Channel  Dir  tdata (low bit up)                         tuser / tlast
// s        in   now_time[63:0] delay_ticks[127:64]         tuser: opcode
//               event_tag[143:128]
// m        out  fired_tag[15:0] timer_enable[16]           tuser: fired, reprogram,
//               interval[48:17], zero fill[55:49]          rejected; tlast: last
//
// An add that finds the queue empty or full goes from S_ADD_START straight to S_ADD_FIN;
// else it walks from the tail toward the head in S_ADD_WALK, moving each entry it passes
// one slot toward the tail, and ends in S_ADD_FIN, via S_ADD_HEAD when the new entry goes to the head.
// A check pushes one result per popped event plus one for the status result; the sequencer
// then returns to idle, where it can take the next request.
// Reset clears count and head, RAM not swept; a stalled result holds the sequencer.
module sorted_timer_event_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned TAG_BITS    = tsq_pkg::TAG_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,   // now_time, delay_ticks, event_tag
    input  logic         i_s_tuser,   // opcode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [55:0]  o_m_tdata,   // fired_tag, timer_enable, interval, zero fill
    output logic [2:0]   o_m_tuser,   // fired, reprogram, rejected
    output logic         o_m_tlast
);
    import tsq_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned EW = TIME_W + TAG_BITS;

    logic          push;
    logic          free;
    t_res          ctrl_res;
    t_res          out_res;
    logic          we;
    logic [PW-1:0] waddr;
    logic [PW-1:0] raddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;

    // Sequencer
    tsq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_opcode (i_s_tuser),
        .i_now    (i_s_tdata[63:0]),
        .i_delay  (i_s_tdata[127:64]),
        .i_tag    (i_s_tdata[143:128]),
        .o_push   (push),
        .i_free   (free),
        .o_res    (ctrl_res),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata)
    );

    // Entry store: deadline above tag
    tsq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result register
    tsq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (ctrl_res),
        .o_free  (free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    // Pack result fields
    assign o_m_tdata = {7'b0, out_res.interval, out_res.enable, out_res.tag};
    assign o_m_tuser = {out_res.rejected, out_res.reprogram, out_res.fired};
    assign o_m_tlast = out_res.last;

endmodule
